@@ sv/ilz_pkg.sv @@
// Shared types and constants of the inverted LZSS byte decoder.
// No dependencies; compiled first.
package ilz_pkg;

  localparam int unsigned WinAw           = 12;    // 4096-byte window
  localparam int unsigned WinDepth        = 1 << WinAw;
  localparam int unsigned StartPosDefault = 4078;  // 0xFEE
  localparam int unsigned CountW          = 32;
  localparam int unsigned LenW            = 5;     // match length 3..18

  localparam logic [7:0]      InvMask   = 8'hFF;
  localparam logic [3:0]      FlagsInit = 4'd8;
  localparam logic [LenW-1:0] LenBias   = 5'd3;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StCopy = 2'b10
  } state_e;

  typedef enum logic [1:0] {
    PhFlag = 2'd0,  // expecting a flag byte
    PhTok  = 2'd1,  // literal or match low byte
    PhHigh = 2'd2   // match high byte
  } phase_e;

  // Window write port.
  typedef struct packed {
    logic             en;
    logic [WinAw-1:0] addr;
    logic [7:0]       data;
  } win_wr_t;

  // Window read port with the fill state used to mask unwritten entries.
  typedef struct packed {
    logic             en;
    logic [WinAw-1:0] addr;
    logic             full;  // whole window written this frame
    logic [WinAw-1:0] fill;  // bytes written this frame, when not full
  } win_rd_t;

endpackage

@@ sv/ilz_in_if.sv @@
// Input channel of the decoder: one compressed byte per transfer.
// Depends on nothing.
interface ilz_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

@@ sv/ilz_out_if.sv @@
// Output channel of the decoder: one decoded byte per transfer.
// Depends on nothing.
interface ilz_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       limit_reached;

  modport source (output valid, output out_byte, output last_of_run,
                  output limit_reached, input ready);
  modport sink   (input valid, input out_byte, input last_of_run,
                  input limit_reached, output ready);
endinterface

@@ sv/ilz_cfg_if.sv @@
// Configuration write channel: carries the output byte limit.
// Depends on ilz_pkg.
interface ilz_cfg_if;
  import ilz_pkg::*;
  logic              valid;
  logic              ready;
  logic [CountW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/inverted_lzss_byte_decoder.sv @@
// Top level of the inverted LZSS byte decoder.
// Depends on ilz_pkg, ilz_in_if, ilz_out_if, ilz_cfg_if and ilz_window.
//
// Usage:
//   in_i  : compressed bytes, one per transfer. Each byte is inverted, then
//           read as flag byte, literal, or one of the two match bytes.
//           frame_start on a byte restarts the frame before that byte.
//   out_o : decoded bytes; last_of_run marks the final byte caused by one
//           input byte, limit_reached the byte that brings the count to the
//           configured limit. Bytes past the limit are never produced.
//   cfg_i : writes output_limit; always ready. Write it only while idle.
// Per input byte:
//   flag byte or match low byte: no output.
//   literal: the next byte is taken once the literal leaves the emit stage.
//   match high byte: n emitted bytes (n = 3..18, less at the limit); the
//   window memory reads one byte per cycle, so a copy runs at one output
//   byte per cycle while the output is not stalled.
// Reset: clears the limit to 0, so input is dropped until it is written.
//   The window needs no clearing pass: an entry not written since the frame
//   began reads as zero from the fill count.
// Stall: the output register holds its byte; one more byte waits in the
//   emit stage, then the copy pauses until out_o.ready returns.
module inverted_lzss_byte_decoder #(
  parameter int unsigned StartPosition = ilz_pkg::StartPosDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ilz_in_if.sink    in_i,
  ilz_out_if.source out_o,
  ilz_cfg_if.sink   cfg_i
);
  import ilz_pkg::*;

  localparam logic [WinAw-1:0] StartPos = StartPosition[WinAw-1:0];

  // control and token state
  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [7:0]        flags_q, flags_d;
  logic [3:0]        frem_q, frem_d;
  logic [7:0]        low_q, low_d;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] limit_q;
  logic [WinAw-1:0]  wp_q;

  // copy sequencer
  logic [WinAw-1:0]  pos_q, pos_d;
  logic [LenW-1:0]   cnt_q, cnt_d;

  // emit stage: one byte waiting for the output register
  logic              s2_valid_q;
  logic              s2_mem_q;   // byte comes from the window read
  logic [7:0]        s2_lit_q;
  logic              s2_last_q;
  logic [7:0]        s2_byte;

  // output register
  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic              out_last_q;
  logic              out_lim_q;

  logic              in_fire, out_free, s2_go, issue, lit_load;
  logic [7:0]        b;
  phase_e            phase_eff;
  logic [7:0]        flags_eff;
  logic [3:0]        frem_eff;
  logic [7:0]        low_eff;
  logic [CountW-1:0] count_eff;
  logic [CountW-1:0] room;
  logic [LenW-1:0]   mlen;
  logic [15:0]       word;
  logic [7:0]        win_data;
  win_wr_t           win_wr;
  win_rd_t           win_rd;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == StIdle) && !s2_valid_q;
  assign in_fire     = in_i.valid && in_i.ready;

  assign out_free = !out_valid_q || out_o.ready;
  assign s2_go    = s2_valid_q && out_free;
  // a read may be issued whenever the emit stage is free in the next cycle
  assign issue    = (state_q == StCopy) && (!s2_valid_q || s2_go);

  assign b    = in_i.data_byte ^ InvMask;
  assign word = {b, low_eff};
  assign mlen = {1'b0, word[3:0]} + LenBias;

  // state as seen after an optional frame restart
  always_comb begin
    if (in_i.frame_start) begin
      phase_eff = PhFlag;
      flags_eff = 8'h00;
      frem_eff  = 4'd0;
      low_eff   = 8'h00;
      count_eff = '0;
    end else begin
      phase_eff = phase_q;
      flags_eff = flags_q;
      frem_eff  = frem_q;
      low_eff   = low_q;
      count_eff = count_q;
    end
  end

  // bytes still allowed before the limit; only read when count_eff < limit
  assign room = limit_q - count_eff;

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    flags_d  = flags_q;
    frem_d   = frem_q;
    low_d    = low_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    lit_load = 1'b0;

    if (in_fire) begin
      phase_d = phase_eff;
      flags_d = flags_eff;
      frem_d  = frem_eff;
      low_d   = low_eff;
      if (count_eff < limit_q) begin
        case (phase_eff)
          PhTok: begin
            if (flags_eff[7]) begin
              lit_load = 1'b1;
              flags_d  = {flags_eff[6:0], 1'b0};
              frem_d   = frem_eff - 4'd1;
              phase_d  = (frem_d == 4'd0) ? PhFlag : PhTok;
            end else begin
              low_d   = b;
              phase_d = PhHigh;
            end
          end
          PhHigh: begin
            pos_d   = word[15:4];
            cnt_d   = (room < CountW'(mlen)) ? room[LenW-1:0] : mlen;
            state_d = StCopy;
            flags_d = {flags_eff[6:0], 1'b0};
            frem_d  = frem_eff - 4'd1;
            phase_d = (frem_d == 4'd0) ? PhFlag : PhTok;
          end
          default: begin
            // flag byte; the unused phase code is taken the same way
            flags_d = b;
            frem_d  = FlagsInit;
            phase_d = PhTok;
          end
        endcase
      end
    end

    if (issue) begin
      pos_d = pos_q + 1'b1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == LenW'(1)) begin
        state_d = StIdle;
      end
    end
  end

  // window ports: write on every emitted byte, read one copy byte a cycle while the emit stage is free
  assign win_wr.en   = s2_go;
  assign win_wr.addr = wp_q;
  assign win_wr.data = s2_byte;

  assign win_rd.en   = issue;
  assign win_rd.addr = pos_q;
  assign win_rd.full = |count_q[CountW-1:WinAw];
  assign win_rd.fill = count_q[WinAw-1:0];

  ilz_window #(
    .StartPosition(StartPosition)
  ) u_window (
    .clk_i    (clk_i),
    .wr_i     (win_wr),
    .rd_i     (win_rd),
    .rd_data_o(win_data)
  );

  assign s2_byte = s2_mem_q ? win_data : s2_lit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      phase_q     <= PhFlag;
      flags_q     <= 8'h00;
      frem_q      <= 4'd0;
      low_q       <= 8'h00;
      count_q     <= '0;
      limit_q     <= '0;
      wp_q        <= StartPos;
      cnt_q       <= '0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      flags_q <= flags_d;
      frem_q  <= frem_d;
      low_q   <= low_d;
      cnt_q   <= cnt_d;

      if (cfg_i.valid) begin
        limit_q <= cfg_i.data;
      end

      // a frame start resets the write position and the count; emission advances them
      if (in_fire && in_i.frame_start) begin
        wp_q    <= StartPos;
        count_q <= '0;
      end else if (s2_go) begin
        wp_q    <= wp_q + 1'b1;
        count_q <= count_q + 1'b1;
      end

      if (lit_load || issue) begin
        s2_valid_q <= 1'b1;
      end else if (s2_go) begin
        s2_valid_q <= 1'b0;
      end

      if (s2_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (lit_load) begin
      s2_mem_q  <= 1'b0;
      s2_lit_q  <= b;
      s2_last_q <= 1'b1;
    end else if (issue) begin
      s2_mem_q  <= 1'b1;
      s2_last_q <= (cnt_q == LenW'(1));
    end
    if (s2_go) begin
      out_byte_q <= s2_byte;
      out_last_q <= s2_last_q;
      out_lim_q  <= ((count_q + 1'b1) == limit_q);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_byte      = out_byte_q;
  assign out_o.last_of_run   = out_last_q;
  assign out_o.limit_reached = out_lim_q;

endmodule

@@ sv/ilz_window.sv @@
// 4096 x 8 history window with registered read, write-to-read forwarding
// and fill-count masking of entries not yet written in this frame.
// Depends on ilz_pkg.
module ilz_window #(
  parameter int unsigned StartPosition = ilz_pkg::StartPosDefault
) (
  input  logic             clk_i,
  input  ilz_pkg::win_wr_t wr_i,
  input  ilz_pkg::win_rd_t rd_i,
  output logic [7:0]       rd_data_o
);
  import ilz_pkg::*;

  localparam logic [WinAw-1:0] StartPos = StartPosition[WinAw-1:0];

  logic [7:0]       mem [WinDepth];
  logic [7:0]       rd_q;
  logic [7:0]       fwd_q;
  logic             hit_q;
  logic             valid_q;
  logic [WinAw-1:0] offset;

  // entries are written in order from the start position
  assign offset = rd_i.addr - StartPos;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_q    <= mem[rd_i.addr];
      fwd_q   <= wr_i.data;
      hit_q   <= wr_i.en && (wr_i.addr == rd_i.addr);
      valid_q <= rd_i.full || (offset < rd_i.fill);
    end
  end

  assign rd_data_o = hit_q ? fwd_q : (valid_q ? rd_q : 8'h00);

endmodule
